### src/rgb2hsb_pkg.sv
// ----------------------------------------------------------------------------
// rgb2hsb_pkg: shared types and constants for the rgb to hsb converter
// Word layouts for the pixel and result channels, and datapath widths.
// ----------------------------------------------------------------------------
package rgb2hsb_pkg;

  // channel and result field widths
  localparam int unsigned CH_W  = 8;
  localparam int unsigned HUE_W = 16;
  localparam int unsigned SAT_W = 17;
  localparam int unsigned BRI_W = 17;

  // divider datapath: divisor up to 6*255, remainder doubled before compare
  localparam int unsigned DIV_W = 11;
  localparam int unsigned REM_W = 12;

  // divider lanes
  localparam int unsigned LANES    = 2;
  localparam int unsigned LANE_HUE = 0;
  localparam int unsigned LANE_SAT = 1;

  // hue divisor used for a gray pixel, any nonzero value works
  localparam logic [DIV_W-1:0] GRAY_DIV = 11'd6;

  // input word: one pixel
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // output word: one hsb result
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [BRI_W-1:0] brightness;
  } hsb_t;

endpackage

### src/rgb_to_hsb_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsb_converter_top: pipelined rgb to hue, saturation, brightness
// An accepted word passes the prep stage, the load stage and the divider steps.
// Throughput is one word per cycle while the output is not stalled, set by the
// two restoring dividers that resolve one quotient bit per pipeline stage.
// The whole pipeline holds while the output word is stalled.
// Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsb_converter_top #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  rgb2hsb_pkg::pixel_t  pixel_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output rgb2hsb_pkg::hsb_t    hsb_o
);

  localparam int unsigned CH_W  = rgb2hsb_pkg::CH_W;
  localparam int unsigned DIV_W = rgb2hsb_pkg::DIV_W;
  localparam int unsigned REM_W = rgb2hsb_pkg::REM_W;
  localparam int unsigned LANES = rgb2hsb_pkg::LANES;
  // quotient bits and divider steps: one integer bit plus the fraction bits
  localparam int unsigned QW    = FRACTION_BITS + 1;
  localparam int unsigned NSTEP = FRACTION_BITS + 1;

  // pipeline advance: hold everything while the output word is stalled
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // ---------------- prep stage: channel max and min ----------------
  logic [CH_W-1:0] max_rg, min_rg, cmax_d, cmin_d;
  logic            vp_q;
  logic [CH_W-1:0] r_q, g_q, b_q, cmax_q, cmin_q;

  always_comb begin
    max_rg = (pixel_i.red > pixel_i.green) ? pixel_i.red : pixel_i.green;
    min_rg = (pixel_i.red < pixel_i.green) ? pixel_i.red : pixel_i.green;
    cmax_d = (pixel_i.blue > max_rg) ? pixel_i.blue : max_rg;
    cmin_d = (pixel_i.blue < min_rg) ? pixel_i.blue : min_rg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q    <= pixel_i.red;
      g_q    <= pixel_i.green;
      b_q    <= pixel_i.blue;
      cmax_q <= cmax_d;
      cmin_q <= cmin_d;
    end
  end

  // ---------------- divider pipeline registers ----------------
  logic             v_q    [NSTEP+1];
  logic [REM_W-1:0] rem_q  [NSTEP+1][LANES];
  logic [DIV_W-1:0] div_q  [NSTEP+1][LANES];
  logic [QW-1:0]    quo_q  [NSTEP+1][LANES];
  // channel max carried alongside the dividers for the brightness
  logic [CH_W-1:0]  bmax_q [NSTEP+1];

  // ---------------- load stage: hue numerator and divisors ----------------
  logic [CH_W-1:0]  dlt;
  logic [REM_W-1:0] d12, r12, g12, b12, d6, num;
  logic             gray;

  always_comb begin
    dlt  = cmax_q - cmin_q;
    gray = (dlt == '0);
    d12  = REM_W'(dlt);
    r12  = REM_W'(r_q);
    g12  = REM_W'(g_q);
    b12  = REM_W'(b_q);
    d6   = (d12 << 2) + (d12 << 1);
    // sector of the largest channel, red then green then blue on ties
    if (r_q == cmax_q) begin
      num = (g_q >= b_q) ? (g12 - b12) : (d6 - (b12 - g12));
    end else if (g_q == cmax_q) begin
      num = (d12 << 1) + b12 - r12;
    end else begin
      num = (d12 << 2) + r12 - g12;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= vp_q;
    end
  end

  // gray or black pixels divide zero by a nonzero divisor, giving zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0][rgb2hsb_pkg::LANE_HUE] <= gray ? '0 : num;
      div_q[0][rgb2hsb_pkg::LANE_HUE] <= gray ? rgb2hsb_pkg::GRAY_DIV : d6[DIV_W-1:0];
      quo_q[0][rgb2hsb_pkg::LANE_HUE] <= '0;
      rem_q[0][rgb2hsb_pkg::LANE_SAT] <= d12;
      div_q[0][rgb2hsb_pkg::LANE_SAT] <= (cmax_q == '0) ? DIV_W'(1) : DIV_W'(cmax_q);
      quo_q[0][rgb2hsb_pkg::LANE_SAT] <= '0;
      bmax_q[0]                       <= cmax_q;
    end
  end

  // ---------------- restoring division, one quotient bit per stage ----------------
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [REM_W-1:0] trial [LANES];
    logic [LANES-1:0] take;

    // first step compares the integer bit, later steps shift in a zero
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 1) begin
          trial[l] = rem_q[k-1][l];
        end else begin
          trial[l] = {rem_q[k-1][l][REM_W-2:0], 1'b0};
        end
        take[l] = (trial[l] >= REM_W'(div_q[k-1][l]));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= take[l] ? (trial[l] - REM_W'(div_q[k-1][l])) : trial[l];
          div_q[k][l] <= div_q[k-1][l];
          quo_q[k][l] <= {quo_q[k-1][l][QW-2:0], take[l]};
        end
        bmax_q[k] <= bmax_q[k-1];
      end
    end
  end

  // ---------------- brightness: cmax/255 ----------------
  // below full scale, cmax/255 is the byte cmax repeated after the binary point
  logic [4*CH_W-1:0] bri_rep;
  logic [QW-1:0]     bri_quo;

  always_comb begin
    bri_rep = {4{bmax_q[NSTEP]}};
    if (bmax_q[NSTEP] == '1) begin
      bri_quo = QW'(1) << FRACTION_BITS;
    end else begin
      bri_quo = QW'(bri_rep[4*CH_W-1 -: FRACTION_BITS]);
    end
  end

  // ---------------- output word ----------------
  assign valid_o          = v_q[NSTEP];
  assign hsb_o.hue        = rgb2hsb_pkg::HUE_W'(quo_q[NSTEP][rgb2hsb_pkg::LANE_HUE]);
  assign hsb_o.saturation = rgb2hsb_pkg::SAT_W'(quo_q[NSTEP][rgb2hsb_pkg::LANE_SAT]);
  assign hsb_o.brightness = rgb2hsb_pkg::BRI_W'(bri_quo);

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the rgb to hsb converter
// Sends pixel words through the valid/stall handshake and checks each hsb
// word against an exact integer model of hue, saturation and brightness.
// The phases cover directed corner pixels, free flow, sender gaps, receiver
// stalls, a long output hold-off that fills the pipeline, and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned PIPE_LATENCY   = FRAC_BITS + 3;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // clock, reset and block inputs, all known from time zero
  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                valid_i = 1'b0;
  logic                stall_i = 1'b0;
  rgb2hsb_pkg::pixel_t pixel_i = '0;
  logic                stall_o;
  logic                valid_o;
  rgb2hsb_pkg::hsb_t   hsb_o;

  // idling controls shared by the sender task and the stall driver
  int unsigned send_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_off_left = 0;

  // expected words and run statistics
  rgb2hsb_pkg::hsb_t hsb_expected_q[$];
  int unsigned mismatches   = 0;
  int unsigned pixels_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  rgb_to_hsb_converter_top #(
    .FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .pixel_i(pixel_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .hsb_o  (hsb_o)
  );

  // 8 ns clock
  always #4 clk_i = ~clk_i;

  // exact hue, saturation and brightness of one pixel, truncated
  function automatic rgb2hsb_pkg::hsb_t hsb_of(rgb2hsb_pkg::pixel_t px);
    bit [31:0] r, g, b, cmax, cmin, span, num;
    rgb2hsb_pkg::hsb_t res;
    r    = 32'(px.red);
    g    = 32'(px.green);
    b    = 32'(px.blue);
    cmax = (r > g) ? r : g;
    cmin = (r < g) ? r : g;
    if (b > cmax) cmax = b;
    if (b < cmin) cmin = b;
    span = cmax - cmin;
    res  = '0;
    res.brightness = rgb2hsb_pkg::BRI_W'((cmax << FRAC_BITS) / 32'd255);
    if (cmax != 0) res.saturation = rgb2hsb_pkg::SAT_W'((span << FRAC_BITS) / cmax);
    if (span != 0) begin
      // sector of the largest channel, red then green then blue on ties
      if (r == cmax) begin
        num = (g >= b) ? (g - b) : (32'd6 * span - (b - g));
      end else if (g == cmax) begin
        num = 32'd2 * span + b - r;
      end else begin
        num = 32'd4 * span + r - g;
      end
      res.hue = rgb2hsb_pkg::HUE_W'((num << FRAC_BITS) / (32'd6 * span));
    end
    return res;
  endfunction

  // random pixel, biased toward gray pixels, ties, tiny channel values and a bright red
  function automatic rgb2hsb_pkg::pixel_t random_pixel();
    rgb2hsb_pkg::pixel_t px;
    logic [7:0]          lvl;
    int unsigned         pick;
    px.red   = 8'($urandom);
    px.green = 8'($urandom);
    px.blue  = 8'($urandom);
    lvl      = 8'($urandom_range(255));
    pick     = $urandom_range(9);
    case (pick)
      0: px = '{red: lvl, green: lvl, blue: lvl};
      1: px.green = px.red;
      2: px.blue = px.red;
      3: px.blue = px.green;
      4: begin
        px.red   = 8'($urandom_range(3));
        px.green = 8'($urandom_range(3));
        px.blue  = 8'($urandom_range(3));
      end
      5: px.red = 8'(px.red | 8'hf0);
      default: ;
    endcase
    return px;
  endfunction

  // receiver side: random stall, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      stall_i       <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // monitor: check output words, record accepted pixels, watchdog
  always @(posedge clk_i) begin
    rgb2hsb_pkg::hsb_t want;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        moved = 1'b1;
        results_seen++;
        if (hsb_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected word hue=%h sat=%h bri=%h", $realtime,
                     hsb_o.hue, hsb_o.saturation, hsb_o.brightness);
        end else begin
          want = hsb_expected_q.pop_front();
          if (hsb_o.hue !== want.hue || hsb_o.saturation !== want.saturation ||
              hsb_o.brightness !== want.brightness) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] word %0d: exp hue=%h sat=%h bri=%h, got hue=%h sat=%h bri=%h",
                       $realtime, results_seen, want.hue, want.saturation,
                       want.brightness, hsb_o.hue, hsb_o.saturation, hsb_o.brightness);
          end
        end
      end
      if (valid_i && !stall_o) begin
        moved = 1'b1;
        pixels_sent++;
        hsb_expected_q.push_back(hsb_of(pixel_i));
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // offer one pixel word, with a random gap first, and wait until it is taken
  task automatic send_pixel(input rgb2hsb_pkg::pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (stall_o);
  endtask

  // stop offering and wait until every expected word has come out
  // it waits first so the word taken at the last edge is already queued
  task automatic wait_drained();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (hsb_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // corner pixels: black, white, gray, primaries, ties and every sector
  task automatic test_directed();
    rgb2hsb_pkg::pixel_t corner_px[$];
    corner_px = '{
      '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
      '{8'd128, 8'd128, 8'd128}, '{8'd1,   8'd1,   8'd1},
      '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
      '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
      '{8'd255, 8'd0,   8'd1},   '{8'd255, 8'd1,   8'd0},
      '{8'd10,  8'd200, 8'd5},   '{8'd3,   8'd7,   8'd250},
      '{8'd1,   8'd0,   8'd0},   '{8'd0,   8'd1,   8'd0},
      '{8'd0,   8'd0,   8'd1},   '{8'd254, 8'd255, 8'd255},
      '{8'd255, 8'd254, 8'd254}, '{8'd255, 8'd254, 8'd0},
      '{8'd170, 8'd85,  8'd170}, '{8'd200, 8'd200, 8'd100},
      '{8'd100, 8'd200, 8'd200}
    };
    send_idle_pct = 0;
    out_stall_pct = 0;
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    wait_drained();
  endtask

  task automatic test_free_flow();
    send_idle_pct = 0;
    out_stall_pct = 0;
    send_random(300);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 86;
    out_stall_pct = 0;
    send_random(250);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    out_stall_pct = 86;
    send_random(250);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 15;
    out_stall_pct = 15;
    send_random(300);
  endtask

  // long output hold-off while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    out_stall_pct = 0;
    hold_off_left = 300;
    send_random(100);
    wait_drained();
  endtask

  // sender pauses until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    send_idle_pct = 0;
    out_stall_pct = 30;
    send_random(70);
    wait_drained();
    send_random(70);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_free_flow();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_drain_pause();

    // let the pipeline settle, catching any stray word
    wait_drained();
    out_stall_pct = 0;
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    mismatches += unsigned'(hsb_expected_q.size());

    $display("covered %0d pixel words and %0d hsb words over directed corners,",
             pixels_sent, results_seen);
    $display("free flow, sender gaps, receiver stalls, a long hold-off and drains");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
